// ----- rtl/core/huffman_tree_decoder_core_macros.svh -----
// Assertion macros for the port-level checker of the Huffman tree decoder core.
`ifndef HUFFMAN_TREE_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_DECODER_CORE_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and disabled while reset is held.
`define HTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define HTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/htd_pkg.sv -----
// Package with the shared types, widths and codes of the Huffman tree decoder core.
`timescale 1ns / 1ps

package htd_pkg;

    // Defaults of the top-level parameters.
    localparam int NODE_COUNT_DEF  = 255;
    localparam int LENGTH_BITS_DEF = 24;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 8;
    localparam int CHILD_W   = 9;
    localparam int JOB_LEN_W = 24;
    localparam int BYTE_W    = 8;
    localparam int SYMBOL_W  = 8;
    localparam int ENTRY_W   = 2 * CHILD_W;

    // Layout of the input tdata word, lowest field first.
    localparam int IDX_LSB   = 0;
    localparam int C0_LSB    = IDX_LSB + INDEX_W;
    localparam int C1_LSB    = C0_LSB + CHILD_W;
    localparam int LEN_LSB   = C1_LSB + CHILD_W;
    localparam int BYTE_LSB  = LEN_LSB + JOB_LEN_W;
    localparam int IN_USED_W = BYTE_LSB + BYTE_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } htd_state_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last_of_byte;
        logic                done_res;
    } htd_result_t;

    typedef struct packed {
        logic        valid;
        htd_result_t result;
    } htd_push_t;

endpackage

// ----- rtl/core/htd_node_mem.sv -----
// Node table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module htd_node_mem #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF,
    parameter int ADDR_W     = $clog2(NODE_COUNT)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [htd_pkg::ENTRY_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [htd_pkg::ENTRY_W-1:0]  rd_data
);

    logic [htd_pkg::ENTRY_W-1:0] node_mem_reg [NODE_COUNT];
    logic [htd_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= node_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/htd_out_reg.sv -----
// Output register that holds one result transaction while the receiver stalls.
`timescale 1ns / 1ps

module htd_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  htd_pkg::htd_push_t     push,
    output logic                   free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [htd_pkg::SYMBOL_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic [0:0]             m_axis_tuser
);

    logic                 valid_reg;
    logic                 valid_next;
    htd_pkg::htd_result_t data_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push.valid && free)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid && free)
        begin
            data_reg <= push.result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg.symbol;
    assign m_axis_tlast  = data_reg.last_of_byte;
    assign m_axis_tuser  = data_reg.done_res;

endmodule

// ----- rtl/core/htd_walker.sv -----
// Tree walk: one node step per cycle unless stalled, symbol count and pending symbol.
`timescale 1ns / 1ps

module htd_walker #(
    parameter int NODE_COUNT  = htd_pkg::NODE_COUNT_DEF,
    parameter int LENGTH_BITS = htd_pkg::LENGTH_BITS_DEF,
    parameter int ADDR_W      = $clog2(NODE_COUNT)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_accept,
    input  logic [htd_pkg::OP_W-1:0]       operation,
    input  logic [htd_pkg::JOB_LEN_W-1:0]  job_length,
    input  logic [htd_pkg::BYTE_W-1:0]     data_byte,
    output logic                           ready,
    input  logic [htd_pkg::ENTRY_W-1:0]    rd_data,
    output logic                           rd_en,
    output logic [ADDR_W-1:0]              rd_addr,
    input  logic                           out_free,
    output htd_pkg::htd_push_t             push
);

    localparam logic [ADDR_W-1:0] ROOT = ADDR_W'(NODE_COUNT - 1);

    htd_pkg::htd_state_t state_reg, state_next;
    logic [ADDR_W-1:0]      cur_node_reg, cur_node_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [2:0]             bit_cnt_reg, bit_cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [htd_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [htd_pkg::SYMBOL_W-1:0] pend_sym_reg, pend_sym_next;
    logic                   pend_done_reg, pend_done_next;

    logic                         bit_val;
    logic [htd_pkg::CHILD_W-1:0]  child;
    logic                         is_leaf;
    logic                         ptr_ok;
    logic [ADDR_W-1:0]            step_node;
    logic [LENGTH_BITS-1:0]       left_dec;
    logic                         stall;
    logic                         byte_end;

    // One walk step: pick the child for the current bit and find the next node.
    always_comb
    begin
        bit_val   = byte_reg[bit_cnt_reg];
        child     = bit_val ? rd_data[htd_pkg::ENTRY_W-1:htd_pkg::CHILD_W]
                            : rd_data[htd_pkg::CHILD_W-1:0];
        is_leaf   = !child[htd_pkg::CHILD_W-1];
        ptr_ok    = 32'(child[htd_pkg::SYMBOL_W-1:0]) < NODE_COUNT;
        step_node = (is_leaf || !ptr_ok) ? ROOT : child[ADDR_W-1:0];
        left_dec  = left_reg - LENGTH_BITS'(1);
        stall     = is_leaf && pend_valid_reg && !out_free;
        byte_end  = (bit_cnt_reg == 3'd7) || (is_leaf && (left_dec == '0));
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        left_next       = left_reg;
        bit_cnt_next    = bit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        byte_next       = byte_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        rd_en           = 1'b1;
        rd_addr         = cur_node_reg;
        push            = '0;

        case (state_reg)
            htd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        htd_pkg::OP_START:
                        begin
                            left_next     = LENGTH_BITS'(job_length);
                            cur_node_next = ROOT;
                        end
                        htd_pkg::OP_DATA:
                        begin
                            if (left_reg != '0)
                            begin
                                byte_next    = data_byte;
                                bit_cnt_next = 3'd0;
                                state_next   = htd_pkg::ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            htd_pkg::ST_WALK:
            begin
                if (stall)
                begin
                    rd_en = 1'b0;
                end
                else
                begin
                    rd_addr       = step_node;
                    cur_node_next = step_node;
                    bit_cnt_next  = bit_cnt_reg + 3'd1;
                    if (is_leaf)
                    begin
                        // The earlier symbol is known not to be the last of this byte.
                        push.valid               = pend_valid_reg;
                        push.result.symbol       = pend_sym_reg;
                        push.result.last_of_byte = 1'b0;
                        push.result.done_res     = pend_done_reg;
                        pend_valid_next          = 1'b1;
                        pend_sym_next            = child[htd_pkg::SYMBOL_W-1:0];
                        pend_done_next           = (left_dec == '0);
                        left_next                = left_dec;
                    end
                    if (byte_end)
                    begin
                        state_next = (is_leaf || pend_valid_reg) ? htd_pkg::ST_FLUSH
                                                                 : htd_pkg::ST_IDLE;
                    end
                end
            end

            htd_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    push.valid               = 1'b1;
                    push.result.symbol       = pend_sym_reg;
                    push.result.last_of_byte = 1'b1;
                    push.result.done_res     = pend_done_reg;
                    pend_valid_next          = 1'b0;
                    state_next               = htd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htd_pkg::ST_IDLE;
            cur_node_reg   <= ROOT;
            left_reg       <= '0;
            bit_cnt_reg    <= 3'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            left_reg       <= left_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
    end

    assign ready = (state_reg == htd_pkg::ST_IDLE);

endmodule

// ----- rtl/core/huffman_tree_decoder_core.sv -----
// Top level of the bit-serial Huffman tree-walk decoder.
`timescale 1ns / 1ps

// Usage. Input transactions arrive on the s_axis channel; tuser carries the
// operation (load node, start job, data byte) and tdata the fields. A load
// transaction writes one node of the table, a start transaction sets the
// number of symbols to decode and returns the walk to the root node. Each
// data byte is walked least significant bit first, one node table read per
// bit, and yields up to eight symbols on the m_axis channel. tlast marks the
// last symbol of a byte and tuser flags the symbol that completes the job.
// Load and start transactions leave the input ready for the next one. A data
// byte is accepted, then walked bit by bit (all eight bits, fewer when the
// job count runs out), and a flush step then releases its final symbol, if
// it has one. Each bit step depends on the node table read of the step
// before, and no new transaction is taken until the walk of a byte is
// through. A byte that arrives with no symbols left produces no transaction.
// Reset clears the walk state, the symbol count and the output register; the
// node table is not cleared and must be loaded before data is sent. When the
// receiver stalls, the output register holds its transaction and the walk
// pauses at the next symbol until the register drains.
module huffman_tree_decoder_core #(
    parameter int NODE_COUNT  = htd_pkg::NODE_COUNT_DEF,
    parameter int LENGTH_BITS = htd_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata fields from bit 0 up: node_index, child_zero, child_one,
    // job_length, data_byte, zero padding.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [htd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser fields from bit 0 up: operation.
    input  logic [htd_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata fields from bit 0 up: symbol.
    output logic [htd_pkg::SYMBOL_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast,
    // tuser fields from bit 0 up: done_res.
    output logic [0:0]                        m_axis_tuser
);

    localparam int ADDR_W = $clog2(NODE_COUNT);

    logic                            in_accept;
    logic [htd_pkg::INDEX_W-1:0]     node_index;
    logic [htd_pkg::CHILD_W-1:0]     child_zero;
    logic [htd_pkg::CHILD_W-1:0]     child_one;
    logic [htd_pkg::JOB_LEN_W-1:0]   job_length;
    logic [htd_pkg::BYTE_W-1:0]      data_byte;

    logic                            wr_en;
    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic [htd_pkg::ENTRY_W-1:0]     rd_data;
    logic                            out_free;
    htd_pkg::htd_push_t              push;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign node_index = s_axis_tdata[htd_pkg::IDX_LSB +: htd_pkg::INDEX_W];
    assign child_zero = s_axis_tdata[htd_pkg::C0_LSB +: htd_pkg::CHILD_W];
    assign child_one  = s_axis_tdata[htd_pkg::C1_LSB +: htd_pkg::CHILD_W];
    assign job_length = s_axis_tdata[htd_pkg::LEN_LSB +: htd_pkg::JOB_LEN_W];
    assign data_byte  = s_axis_tdata[htd_pkg::BYTE_LSB +: htd_pkg::BYTE_W];

    // Loads to nodes beyond the table are dropped.
    assign wr_en = in_accept && (s_axis_tuser == htd_pkg::OP_LOAD)
                   && (32'(node_index) < NODE_COUNT);

    htd_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_node_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (node_index[ADDR_W-1:0]),
        .wr_data ({child_one, child_zero}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    htd_walker #(
        .NODE_COUNT  (NODE_COUNT),
        .LENGTH_BITS (LENGTH_BITS),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .operation  (s_axis_tuser),
        .job_length (job_length),
        .data_byte  (data_byte),
        .ready      (s_axis_tready),
        .rd_data    (rd_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .out_free   (out_free),
        .push       (push)
    );

    htd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/htd_core_checker.sv -----
// Port-level assertion checker for the Huffman tree decoder core, with its bind.
`timescale 1ns / 1ps
`include "huffman_tree_decoder_core_macros.svh"

module htd_core_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [htd_pkg::OP_W-1:0]      s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [htd_pkg::SYMBOL_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic [0:0]                    m_axis_tuser
);

    // A stalled result transaction keeps its payload.
    `HTD_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

    // The symbol that completes a job is always the last one of its byte.
    `HTD_ASSERT(a_done_is_last, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast, "done without last")

    // After a load or start transaction the input is ready again in the next cycle.
    `HTD_ASSERT(a_ctrl_one_cycle, clk, rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == htd_pkg::OP_LOAD || s_axis_tuser == htd_pkg::OP_START) |=> s_axis_tready, "control transaction held the input")

    // Reset empties the output register.
    `HTD_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind huffman_tree_decoder_core htd_core_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/huffman_decode_checker.sv -----
// Checker that predicts and compares the symbols of the Huffman tree decoder core.
`timescale 1ns / 1ps

module huffman_decode_checker #(
    parameter int NODE_COUNT  = htd_pkg::NODE_COUNT_DEF,
    parameter int LENGTH_BITS = htd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [htd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [htd_pkg::OP_W-1:0]      s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [htd_pkg::SYMBOL_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic [0:0]                    m_axis_tuser,
    output int                            symbols_owed,
    output int                            error_count
);
    import htd_pkg::*;

    localparam int ROOT_NODE    = NODE_COUNT - 1;
    localparam int LEAF_LIMIT   = 256;
    localparam int REPORT_LIMIT = 10;

    logic [ENTRY_W-1:0]     node_copy [0:NODE_COUNT-1];
    int                     walk_node;
    logic [LENGTH_BITS-1:0] symbols_left;
    htd_result_t            pending_symbols [$];

    // Applies one input transaction to the private copy of the decoder state
    // and queues every symbol it should produce.
    task automatic decode_transaction(input logic [OP_W-1:0] op,
                                      input logic [IN_DATA_W-1:0] word);
        int                index;
        int                child;
        int                bit_pos;
        logic [ENTRY_W-1:0] entry;
        logic [BYTE_W-1:0] data_val;
        htd_result_t       held;
        bit                have_held;
        index     = int'(word[IDX_LSB +: INDEX_W]);
        data_val  = word[BYTE_LSB +: BYTE_W];
        have_held = 1'b0;
        held      = '0;
        case (op)
            OP_LOAD:
            begin
                if (index < NODE_COUNT)
                begin
                    node_copy[index] = {word[C1_LSB +: CHILD_W], word[C0_LSB +: CHILD_W]};
                end
            end
            OP_START:
            begin
                symbols_left = LENGTH_BITS'(word[LEN_LSB +: JOB_LEN_W]);
                walk_node    = ROOT_NODE;
            end
            OP_DATA:
            begin
                for (bit_pos = 0; bit_pos < BYTE_W && symbols_left != 0; bit_pos++)
                begin
                    if (walk_node >= NODE_COUNT)
                    begin
                        walk_node = ROOT_NODE;
                    end
                    entry = node_copy[walk_node];
                    child = data_val[bit_pos] ? int'(entry[ENTRY_W-1 -: CHILD_W])
                                              : int'(entry[CHILD_W-1:0]);
                    if (child < LEAF_LIMIT)
                    begin
                        // The previous symbol of this byte is now known not to be the last.
                        if (have_held)
                        begin
                            pending_symbols.push_back(held);
                        end
                        symbols_left      = symbols_left - 1'b1;
                        held.symbol       = SYMBOL_W'(child);
                        held.last_of_byte = 1'b0;
                        held.done_res     = (symbols_left == 0);
                        have_held         = 1'b1;
                        walk_node         = ROOT_NODE;
                    end
                    else if (child - LEAF_LIMIT < NODE_COUNT)
                    begin
                        walk_node = child - LEAF_LIMIT;
                    end
                    else
                    begin
                        walk_node = ROOT_NODE;
                    end
                end
                if (have_held)
                begin
                    held.last_of_byte = 1'b1;
                    pending_symbols.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_error(input string what, input htd_result_t want);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%s: expected symbol %02h last %0b done %0b, got symbol %02h last %0b done %0b",
                     what, want.symbol, want.last_of_byte, want.done_res,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
    endtask

    initial
    begin
        error_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_symbols.delete();
            walk_node    = ROOT_NODE;
            symbols_left = '0;
            symbols_owed <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_symbols.size() == 0)
                begin
                    report_error("unexpected output transaction", '0);
                end
                else
                begin
                    if (m_axis_tdata !== pending_symbols[0].symbol
                        || m_axis_tlast !== pending_symbols[0].last_of_byte
                        || m_axis_tuser[0] !== pending_symbols[0].done_res)
                    begin
                        report_error("symbol mismatch", pending_symbols[0]);
                    end
                    void'(pending_symbols.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_transaction(s_axis_tuser, s_axis_tdata);
            end
            symbols_owed <= pending_symbols.size();
        end
    end

endmodule

// ----- tb/tb_huffman_tree_decoder_core.sv -----
// Testbench top for the Huffman tree decoder core: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_huffman_tree_decoder_core;
    import htd_pkg::*;

    // Operation code 3 is not defined by the block; it must be dropped silently.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ROOT_NODE      = NODE_COUNT_DEF - 1;
    localparam int LEAF_LIMIT     = 256;
    localparam int RANDOM_ITEMS   = 210;
    // Stall phases of the receiver can follow one another, but a chain long
    // enough to fill this quiet stretch is vanishingly unlikely, so reaching
    // it means the block is stuck.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed after the last expected symbol for any stray output.
    localparam int TAIL_CYCLES    = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [SYMBOL_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    int symbols_owed;
    int error_count;
    int stall_cycles;
    int ready_hold;
    int ready_choice;
    int burst_left;
    int items_sent;

    // The stimulus only ever points a child at a node that is already loaded,
    // so the walk can never reach a table entry that was not written.
    bit node_loaded [0:NODE_COUNT_DEF-1];
    int loaded_list [$];

    huffman_tree_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    huffman_decode_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .symbols_owed  (symbols_owed),
        .error_count   (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: runs of ready and stalls of random length, independent of the sender.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            ready_choice = $urandom_range(0, 9);
            if (ready_choice < 5)
            begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 19);
            end
            else if (ready_choice < 8)
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(4, 11);
            end
        end
    end

    // Watchdog: ends the run when neither channel completes a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(input int index, input int c0,
                                                         input int c1,
                                                         input logic [JOB_LEN_W-1:0] len,
                                                         input int data_val);
        logic [IN_DATA_W-1:0] word;
        word                          = '0;
        word[IDX_LSB +: INDEX_W]      = INDEX_W'(index);
        word[C0_LSB +: CHILD_W]       = CHILD_W'(c0);
        word[C1_LSB +: CHILD_W]       = CHILD_W'(c1);
        word[LEN_LSB +: JOB_LEN_W]    = len;
        word[BYTE_LSB +: BYTE_W]      = BYTE_W'(data_val);
        return word;
    endfunction

    // Presents one transaction and returns at the clock edge where it is taken.
    // Transactions go out in bursts; a new burst may begin after an idle gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(16, 40);
            end
            else
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 10);
            end
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Fields that an operation does not use are filled with random values.
    task automatic load_node(input int index, input int c0, input int c1);
        send_item(OP_LOAD, pack_fields(index, c0, c1, JOB_LEN_W'($urandom()),
                                       $urandom_range(0, 255)));
        if (!node_loaded[index])
        begin
            node_loaded[index] = 1'b1;
            loaded_list.push_back(index);
        end
        items_sent++;
    endtask

    task automatic start_job(input logic [JOB_LEN_W-1:0] len);
        send_item(OP_START, pack_fields($urandom_range(0, 254), $urandom_range(0, 510),
                                        $urandom_range(0, 510), len,
                                        $urandom_range(0, 255)));
        items_sent++;
    endtask

    task automatic send_byte(input int data_val);
        send_item(OP_DATA, pack_fields($urandom_range(0, 254), $urandom_range(0, 510),
                                       $urandom_range(0, 510), JOB_LEN_W'($urandom()),
                                       data_val));
        items_sent++;
    endtask

    task automatic send_unused_op();
        send_item(OP_UNUSED, pack_fields($urandom_range(0, 254), $urandom_range(0, 510),
                                         $urandom_range(0, 510), JOB_LEN_W'($urandom()),
                                         $urandom_range(0, 255)));
        items_sent++;
    endtask

    // Holds the sender off until every predicted symbol has been received.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (symbols_owed != 0) @(posedge clk);
    endtask

    // A child is mostly a leaf; otherwise it points to a node already loaded.
    function automatic int pick_child();
        if (loaded_list.size() == 0 || $urandom_range(0, 99) < 60)
        begin
            return $urandom_range(0, 255);
        end
        return LEAF_LIMIT + loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // Mostly short jobs so the count runs out inside bytes; now and then the
    // extremes and a full-width random length.
    function automatic logic [JOB_LEN_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return '1;
        end
        else if (sel == 2)
        begin
            return JOB_LEN_W'($urandom());
        end
        return JOB_LEN_W'($urandom_range(1, 24));
    endfunction

    initial
    begin
        int index;
        int sel;
        int tree_loads;
        int byte_count;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        m_axis_tready = 1'b0;
        ready_hold    = 0;
        stall_cycles  = 0;
        burst_left    = 0;
        items_sent    = 0;
        foreach (node_loaded[i])
        begin
            node_loaded[i] = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A small tree: the root goes to node 1 on a zero bit
        // and emits C3 on a one bit; node 1 emits 5A on zero and goes to node 0
        // on one; node 0 emits the extreme symbols 00 and FF.
        load_node(0, 0, 255);
        load_node(1, 'h5A, LEAF_LIMIT + 0);
        load_node(ROOT_NODE, LEAF_LIMIT + 1, 'hC3);
        // No job started yet, so the byte is dropped.
        send_byte('hFF);
        // A zero-length job emits nothing and raises no done.
        start_job('0);
        send_byte('h00);
        // Four symbols from the first byte; the next byte ends the job after
        // one symbol and the rest of its bits are ignored.
        start_job(JOB_LEN_W'(5));
        send_byte('h00);
        send_byte('hFF);
        // The count is exhausted, so this byte is ignored.
        send_byte('h5A);
        // The longest job: full bytes and a code carried across a byte boundary.
        start_job('1);
        send_byte('hFF);
        send_byte('h01);
        send_byte('h02);
        send_byte('h01);
        // A start in the middle of a code returns the walk to the root.
        start_job(JOB_LEN_W'(3));
        send_byte('h06);
        // A load while a job is in flight must not disturb the walk.
        start_job(JOB_LEN_W'(6));
        send_byte('h01);
        load_node(1, ROOT_NODE + LEAF_LIMIT, 0);
        send_byte('h01);
        send_unused_op();
        send_byte('hFF);
        load_node(ROOT_NODE, 0, ROOT_NODE + LEAF_LIMIT);
        send_byte('hAA);
        wait_until_drained();

        // Random part: each round may rebuild part of the tree, then starts a
        // job and feeds it a few bytes, with the odd load or undefined
        // operation slipped in between the bytes.
        while (items_sent < RANDOM_ITEMS)
        begin
            tree_loads = $urandom_range(0, 4);
            repeat (tree_loads)
            begin
                index = ($urandom_range(0, 3) == 0) ? ROOT_NODE : $urandom_range(0, 254);
                load_node(index, pick_child(), pick_child());
            end
            start_job(pick_length());
            byte_count = $urandom_range(1, 8);
            repeat (byte_count)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    load_node($urandom_range(0, 254), pick_child(), pick_child());
                end
                else if (sel < 11)
                begin
                    send_unused_op();
                end
                send_byte($urandom_range(0, 255));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                wait_until_drained();
            end
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && symbols_owed == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- huffman_tree_decoder_core.f -----
+incdir+rtl/core
rtl/core/htd_pkg.sv
rtl/core/htd_node_mem.sv
rtl/core/htd_out_reg.sv
rtl/core/htd_walker.sv
rtl/core/huffman_tree_decoder_core.sv
rtl/core/htd_core_checker.sv
tb/huffman_decode_checker.sv
tb/tb_huffman_tree_decoder_core.sv
